// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/eatrm_pkg.sv -----
// Types, constants and arithmetic helpers for the Euler angle to rotation matrix block.
package eatrm_pkg;

    localparam int ANGLE_W         = 16;
    localparam int OUT_W           = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int INT_FRAC        = 30;
    localparam int ANGLE_SHIFT     = INT_FRAC - ANGLE_FRAC_BITS;
    localparam int ROUND_SHIFT     = INT_FRAC - OUT_FRAC_BITS;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_COUNT      = 24;
    localparam int NUM_LANES       = 3;

    localparam int WRAP_W  = 34;
    localparam int PHASE_W = 32;
    localparam int VEC_W   = 33;
    localparam int SUM_W   = 34;
    localparam int QOUT_W  = SUM_W - ROUND_SHIFT + 1;

    localparam logic signed [WRAP_W-1:0] Q_PI      = 34'sd3373259426;
    localparam logic signed [WRAP_W-1:0] Q_HALF_PI = 34'sd1686629713;
    localparam logic signed [WRAP_W-1:0] Q_TWO_PI  = 34'sd6746518852;
    localparam logic signed [VEC_W-1:0]  Q_GAIN    = 33'sd652032874;

    localparam logic signed [PHASE_W-1:0] ATAN_Q30 [ATAN_COUNT] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128
    };

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] m11;
        logic signed [OUT_W-1:0] m12;
        logic signed [OUT_W-1:0] m13;
        logic signed [OUT_W-1:0] m21;
        logic signed [OUT_W-1:0] m22;
        logic signed [OUT_W-1:0] m23;
        logic signed [OUT_W-1:0] m31;
        logic signed [OUT_W-1:0] m32;
        logic signed [OUT_W-1:0] m33;
    } t_out;

    typedef struct packed {
        logic signed [PHASE_W-1:0] a;
        logic signed [VEC_W-1:0]   x;
        logic signed [VEC_W-1:0]   y;
        logic                      neg;
    } t_lane;

    typedef t_lane [NUM_LANES-1:0] t_lanes;

    function automatic logic signed [VEC_W-1:0] qmul(input logic signed [VEC_W-1:0] a,
                                                    input logic signed [VEC_W-1:0] b);
        logic signed [2*VEC_W-1:0] p;
        p = a * b;
        p = p + $signed((2*VEC_W)'(64'd1 << (INT_FRAC - 1)));
        return p[INT_FRAC+VEC_W-1:INT_FRAC];
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W:0]    w;
        logic signed [QOUT_W-1:0] q;
        logic signed [QOUT_W-1:0] one;
        w   = $signed({v[SUM_W-1], v}) + $signed((SUM_W+1)'(64'd1 << (ROUND_SHIFT - 1)));
        q   = w[SUM_W:ROUND_SHIFT];
        one = $signed(QOUT_W'(64'd1 << OUT_FRAC_BITS));
        if (q > one) begin
            q = one;
        end else if (q < -one) begin
            q = -one;
        end
        return q[OUT_W-1:0];
    endfunction

endpackage

// ----- src/eatrm_prep.sv -----
// Angle scaling, wrapping into plus or minus pi and folding into plus or minus pi/2.
module eatrm_prep import eatrm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_in    i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_lanes o_lanes
);

    logic                      r_v1;
    logic                      r_v2;
    logic signed [WRAP_W-1:0]  r_wrap [NUM_LANES];
    logic signed [WRAP_W-1:0]  n_wrap [NUM_LANES];
    t_lanes                    r_lanes;
    t_lanes                    n_lanes;
    logic signed [ANGLE_W-1:0] raw [NUM_LANES];
    logic                      rdy1;
    logic                      rdy2;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_lanes = r_lanes;

    always_comb begin
        logic signed [WRAP_W-1:0] a;
        raw[0] = i_data.roll_angle;
        raw[1] = i_data.pitch_angle;
        raw[2] = i_data.yaw_angle;
        for (int l = 0; l < NUM_LANES; l++) begin
            a = WRAP_W'(raw[l]) <<< ANGLE_SHIFT;
            if (a > Q_PI) begin
                a = a - Q_TWO_PI;
            end else if (a < -Q_PI) begin
                a = a + Q_TWO_PI;
            end
            n_wrap[l] = a;
        end
    end

    always_comb begin
        logic signed [WRAP_W-1:0] a;
        logic                     neg;
        for (int l = 0; l < NUM_LANES; l++) begin
            a   = r_wrap[l];
            neg = 1'b0;
            if (a > Q_HALF_PI) begin
                a   = a - Q_PI;
                neg = 1'b1;
            end else if (a < -Q_HALF_PI) begin
                a   = a + Q_PI;
                neg = 1'b1;
            end
            n_lanes[l].a   = a[PHASE_W-1:0];
            n_lanes[l].x   = Q_GAIN;
            n_lanes[l].y   = '0;
            n_lanes[l].neg = neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
        if (rdy1 && i_valid) begin
            r_wrap <= n_wrap;
        end
        if (rdy2 && r_v1) begin
            r_lanes <= n_lanes;
        end
    end

endmodule

// ----- src/eatrm_cell.sv -----
// One CORDIC rotation step for the three angle lanes.
module eatrm_cell import eatrm_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_lanes i_lanes,
    output logic   o_valid,
    input  logic   i_ready,
    output t_lanes o_lanes
);

    localparam logic signed [PHASE_W-1:0] ATAN = ATAN_Q30[STAGE];

    logic   r_valid;
    t_lanes r_lanes;
    t_lanes n_lanes;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

    always_comb begin
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        for (int l = 0; l < NUM_LANES; l++) begin
            xs = $signed(i_lanes[l].x) >>> STAGE;
            ys = $signed(i_lanes[l].y) >>> STAGE;
            n_lanes[l].neg = i_lanes[l].neg;
            if (!i_lanes[l].a[PHASE_W-1]) begin
                n_lanes[l].x = i_lanes[l].x - ys;
                n_lanes[l].y = i_lanes[l].y + xs;
                n_lanes[l].a = i_lanes[l].a - ATAN;
            end else begin
                n_lanes[l].x = i_lanes[l].x + ys;
                n_lanes[l].y = i_lanes[l].y - xs;
                n_lanes[l].a = i_lanes[l].a + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_lanes <= n_lanes;
        end
    end

endmodule

// ----- src/eatrm_mat.sv -----
// Sign correction, products, sums and output rounding for the nine matrix entries.
module eatrm_mat import eatrm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_lanes i_lanes,
    output logic   o_valid,
    input  logic   i_ready,
    output t_out   o_data
);

    logic                    r_v0;
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    logic signed [VEC_W-1:0] r_s [NUM_LANES];
    logic signed [VEC_W-1:0] r_c [NUM_LANES];
    logic signed [VEC_W-1:0] r_p1 [8];
    logic signed [VEC_W-1:0] r_sth1;
    logic signed [VEC_W-1:0] r_p2 [8];
    logic signed [VEC_W-1:0] r_t2 [4];
    logic signed [VEC_W-1:0] r_sth2;
    t_out                    r_out;
    t_out                    n_out;
    logic                    rdy0;
    logic                    rdy1;
    logic                    rdy2;
    logic                    rdy3;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign rdy0    = !r_v0 || rdy1;
    assign o_ready = rdy0;
    assign o_valid = r_v3;
    assign o_data  = r_out;

    always_comb begin
        n_out.m11 = to_out(SUM_W'(r_p2[0]));
        n_out.m12 = to_out(SUM_W'(r_t2[0]) - SUM_W'(r_p2[2]));
        n_out.m13 = to_out(SUM_W'(r_p2[3]) + SUM_W'(r_t2[1]));
        n_out.m21 = to_out(SUM_W'(r_p2[5]));
        n_out.m22 = to_out(SUM_W'(r_p2[4]) + SUM_W'(r_t2[2]));
        n_out.m23 = to_out(SUM_W'(r_t2[3]) - SUM_W'(r_p2[1]));
        n_out.m31 = to_out(-SUM_W'(r_sth2));
        n_out.m32 = to_out(SUM_W'(r_p2[6]));
        n_out.m33 = to_out(SUM_W'(r_p2[7]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
        if (rdy0 && i_valid) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_s[l] <= i_lanes[l].neg ? -i_lanes[l].y : i_lanes[l].y;
                r_c[l] <= i_lanes[l].neg ? -i_lanes[l].x : i_lanes[l].x;
            end
        end
        if (rdy1 && r_v0) begin
            r_p1[0] <= qmul(r_c[2], r_c[1]);
            r_p1[1] <= qmul(r_c[2], r_s[0]);
            r_p1[2] <= qmul(r_c[0], r_s[2]);
            r_p1[3] <= qmul(r_s[0], r_s[2]);
            r_p1[4] <= qmul(r_c[0], r_c[2]);
            r_p1[5] <= qmul(r_c[1], r_s[2]);
            r_p1[6] <= qmul(r_c[1], r_s[0]);
            r_p1[7] <= qmul(r_c[0], r_c[1]);
            r_sth1  <= r_s[1];
        end
        if (rdy2 && r_v1) begin
            r_p2    <= r_p1;
            r_t2[0] <= qmul(r_p1[1], r_sth1);
            r_t2[1] <= qmul(r_p1[4], r_sth1);
            r_t2[2] <= qmul(r_p1[3], r_sth1);
            r_t2[3] <= qmul(r_p1[2], r_sth1);
            r_sth2  <= r_sth1;
        end
        if (rdy3 && r_v2) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- src/euler_angles_to_rotation_matrix.sv -----
// Top level: Z-Y-X Euler angles to direction cosine matrix, fully pipelined.
// Takes roll, pitch and yaw in signed Q2.13 radians and returns the nine entries of
// the Z-Y-X direction cosine matrix in signed Q1.14, rounded and saturated to plus or
// minus one. One transaction is accepted every cycle while o_stall is low. Two stages
// wrap and fold the angles, one CORDIC cell per stage forms sine and cosine, and four
// stages correct signs, multiply twice and add and round. Every stage holds its data
// while stalled and fills bubbles, so input keeps flowing while a finished result
// waits on the output.
`include "assert_macros.svh"

module euler_angles_to_rotation_matrix import eatrm_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(1 << OUT_FRAC_BITS);

    t_lanes w_lanes [CORDIC_STAGES+1];
    logic   w_valid [CORDIC_STAGES+1];
    logic   w_ready [CORDIC_STAGES+1];
    logic   prep_ready;
    logic   w_m11_ok;
    logic   w_m22_ok;

    assign o_stall  = !prep_ready;
    assign w_m11_ok = (o_data.m11 <= ONE_OUT) && (o_data.m11 >= -ONE_OUT);
    assign w_m22_ok = (o_data.m22 <= ONE_OUT) && (o_data.m22 >= -ONE_OUT);

    eatrm_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (prep_ready),
        .i_data  (i_data),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_lanes (w_lanes[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        eatrm_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_lanes (w_lanes[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_lanes (w_lanes[g+1])
        );
    end

    eatrm_mat u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[CORDIC_STAGES]),
        .o_ready (w_ready[CORDIC_STAGES]),
        .i_lanes (w_lanes[CORDIC_STAGES]),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_data  (o_data)
    );

    `ASSERT_IMPLY(a_stall_only_when_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `ASSERT_IMPLY(a_m11_range, i_clk, i_rst_n, o_valid, w_m11_ok)
    `ASSERT_IMPLY(a_m22_range, i_clk, i_rst_n, o_valid, w_m22_ok)

endmodule

// ----- bench/tb_euler_angles_to_rotation_matrix.sv -----
// Testbench for the Euler angle to direction cosine matrix block: table, random and stall checks.
`timescale 1ns / 100ps

module tb_euler_angles_to_rotation_matrix import eatrm_pkg::*;;

    localparam int N_STAGES    = 16;
    localparam int LATENCY     = N_STAGES + 6;
    localparam int N_RANDOM    = 1530;
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam longint Q30_GAIN    = 64'sd652032874;
    localparam int ANGLE_MAX   = 25736;

    typedef struct {
        t_in  angles;
        bit   has_fixed;
        t_out fixed;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    t_out   matrix_queue[$];
    int     fail_count;
    int     result_count;
    int     sent_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    longint atan_tab[24];

    euler_angles_to_rotation_matrix i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(200ms);
        $display("FAIL euler_angles_to_rotation_matrix");
        $finish;
    end

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return floor_shift(a * b + (64'sd1 <<< 29), 30);
    endfunction

    task automatic sin_cos(input logic signed [15:0] ang, output longint s, output longint c);
        longint a;
        longint x;
        longint y;
        longint t;
        bit     flip;
        a = longint'(ang) * (64'sd1 <<< 17);
        x = Q30_GAIN;
        y = 0;
        flip = 1'b0;
        while (a > Q30_PI) a -= Q30_TWO_PI;
        while (a < -Q30_PI) a += Q30_TWO_PI;
        if (a > Q30_HALF_PI) begin
            a -= Q30_PI;
            flip = 1'b1;
        end else if (a < -Q30_HALF_PI) begin
            a += Q30_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < N_STAGES; i++) begin
            if (a >= 0) begin
                t = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                a -= atan_tab[i];
            end else begin
                t = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                a += atan_tab[i];
            end
            x = t;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic logic signed [15:0] to_q14(longint v);
        longint r;
        r = floor_shift(v + (64'sd1 <<< 15), 16);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    task automatic predict_matrix(input t_in ang, output t_out m);
        longint sphi, cphi, sth, cth, spsi, cpsi;
        sin_cos(ang.roll_angle, sphi, cphi);
        sin_cos(ang.pitch_angle, sth, cth);
        sin_cos(ang.yaw_angle, spsi, cpsi);
        m.m11 = to_q14(mul_q30(cpsi, cth));
        m.m12 = to_q14(mul_q30(mul_q30(cpsi, sphi), sth) - mul_q30(cphi, spsi));
        m.m13 = to_q14(mul_q30(sphi, spsi) + mul_q30(mul_q30(cphi, cpsi), sth));
        m.m21 = to_q14(mul_q30(cth, spsi));
        m.m22 = to_q14(mul_q30(cphi, cpsi) + mul_q30(mul_q30(sphi, spsi), sth));
        m.m23 = to_q14(mul_q30(mul_q30(cphi, spsi), sth) - mul_q30(cpsi, sphi));
        m.m31 = to_q14(-sth);
        m.m32 = to_q14(mul_q30(cth, sphi));
        m.m33 = to_q14(mul_q30(cphi, cth));
    endtask

    task automatic send_angles(input t_in ang);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= ang;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic push_and_send(input t_row row);
        t_out m;
        if (row.has_fixed) begin
            m = row.fixed;
        end else begin
            predict_matrix(row.angles, m);
        end
        matrix_queue.push_back(m);
        send_angles(row.angles);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(9))
            0: return 16'(ANGLE_MAX);
            1: return -16'(ANGLE_MAX);
            2: return 16'($urandom_range(65535));
            3: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($signed($urandom_range(2 * ANGLE_MAX)) - ANGLE_MAX);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (matrix_queue.size() == 0) begin
                $error("unexpected transaction %h", o_data);
                fail_count++;
            end else begin
                want = matrix_queue.pop_front();
                if (o_data.m11 !== want.m11) begin
                    $error("m11 exp %0d got %0d", want.m11, o_data.m11); fail_count++;
                end
                if (o_data.m12 !== want.m12) begin
                    $error("m12 exp %0d got %0d", want.m12, o_data.m12); fail_count++;
                end
                if (o_data.m13 !== want.m13) begin
                    $error("m13 exp %0d got %0d", want.m13, o_data.m13); fail_count++;
                end
                if (o_data.m21 !== want.m21) begin
                    $error("m21 exp %0d got %0d", want.m21, o_data.m21); fail_count++;
                end
                if (o_data.m22 !== want.m22) begin
                    $error("m22 exp %0d got %0d", want.m22, o_data.m22); fail_count++;
                end
                if (o_data.m23 !== want.m23) begin
                    $error("m23 exp %0d got %0d", want.m23, o_data.m23); fail_count++;
                end
                if (o_data.m31 !== want.m31) begin
                    $error("m31 exp %0d got %0d", want.m31, o_data.m31); fail_count++;
                end
                if (o_data.m32 !== want.m32) begin
                    $error("m32 exp %0d got %0d", want.m32, o_data.m32); fail_count++;
                end
                if (o_data.m33 !== want.m33) begin
                    $error("m33 exp %0d got %0d", want.m33, o_data.m33); fail_count++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        t_out ident;
        int   wait_cycles;
        atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                     16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                     262144, 131072, 65536, 32768, 16384, 8192,
                     4096, 2048, 1024, 512, 256, 128};
        fail_count    = 0;
        result_count  = 0;
        sent_count    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The zero rotation gives the identity matrix.
        ident = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                  16'sd0, 16'sd0, 16'sd16384};
        row = '{angles: '0, has_fixed: 1'b1, fixed: ident};
        rows.push_back(row);
        row.has_fixed = 1'b0;
        for (int b = 0; b < $bits(t_in); b += 5) begin
            row.angles = '0;
            row.angles[b] = 1'b1;
            rows.push_back(row);
        end
        row.angles = '{16'sd25736, 16'sd25736, 16'sd25736};    rows.push_back(row);
        row.angles = '{-16'sd25736, -16'sd25736, -16'sd25736}; rows.push_back(row);
        row.angles = '{16'sd12868, 16'sd12868, -16'sd12868};   rows.push_back(row);
        row.angles = '{16'sd12869, -16'sd12869, 16'sd12867};   rows.push_back(row);
        // Angles past plus or minus pi exercise the wrap logic; the last row stays within that range.
        row.angles = '{16'sh7FFF, 16'sh8000, 16'sd25737};      rows.push_back(row);
        row.angles = '{16'sh8000, 16'sh7FFF, -16'sd25737};     rows.push_back(row);
        row.angles = '{16'shFFFF, 16'sh5555, 16'shAAAA};       rows.push_back(row);
        foreach (rows[r]) push_and_send(rows[r]);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle_pct = 85;
                recv_idle_pct = 7;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (n == 0) begin
                send_idle_pct = 7;
                recv_idle_pct = 85;
            end
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (matrix_queue.size() != 0);
            end
            row.has_fixed = 1'b0;
            row.angles = '{rand_angle(), rand_angle(), rand_angle()};
            push_and_send(row);
        end
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (matrix_queue.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("Sent %0d angle sets, checked %0d matrices under mixed stall patterns.",
                 sent_count, result_count);
        if (fail_count == 0 && matrix_queue.size() == 0) begin
            $display("PASS euler_angles_to_rotation_matrix");
        end else begin
            $display("FAIL euler_angles_to_rotation_matrix");
        end
        $finish;
    end

endmodule
